// ----- rtl/mrss_pkg.sv -----
`timescale 1ns / 1ps

package mrss_pkg;

	localparam int FIFO_DEPTH = 64;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);

	// item operations
	localparam logic [2:0] OP_MSG      = 3'd0;
	localparam logic [2:0] OP_SX_BEGIN = 3'd1;
	localparam logic [2:0] OP_SX_DATA  = 3'd2;
	localparam logic [2:0] OP_SX_END   = 3'd3;
	localparam logic [2:0] OP_READ     = 3'd4;
	localparam logic [2:0] OP_PEEK     = 3'd5;

	// configuration register indexes
	localparam logic CFG_MANUF_ID   = 1'b0;
	localparam logic CFG_PRODUCT_ID = 1'b1;

	// status byte codes
	localparam logic [7:0] ST_SYSEX    = 8'hF0;
	localparam logic [7:0] ST_EOX      = 8'hF7;
	localparam logic [7:0] ST_REALTIME = 8'hF8;
	localparam logic [7:0] ST_NONE     = 8'h00;

	localparam logic [6:0] MANUF_ID_RST   = 7'd125;
	localparam logic [6:0] PRODUCT_ID_RST = 7'd0;

	typedef logic [PTR_W-1:0] ptr_t;

endpackage

// ----- rtl/mrss_if.sv -----
`timescale 1ns / 1ps

interface mrss_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [7:0] status_byte;
	logic [6:0] data_first;
	logic [6:0] data_second;
	logic [1:0] message_length;
	logic [7:0] payload_byte;

	modport source (
		output valid, op, status_byte, data_first, data_second, message_length,
		payload_byte,
		input  ready
	);
	modport sink (
		input  valid, op, status_byte, data_first, data_second, message_length,
		payload_byte,
		output ready
	);
endinterface

interface mrss_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_byte;
	logic       was_empty;
	logic [2:0] bytes_dropped;
	logic [5:0] fill_level;

	modport source (
		output valid, read_byte, was_empty, bytes_dropped, fill_level,
		input  ready
	);
	modport sink (
		input  valid, read_byte, was_empty, bytes_dropped, fill_level,
		output ready
	);
endinterface

// ----- rtl/midi_running_status_serializer_core.sv -----
`timescale 1ns / 1ps

// MIDI running-status serializer in front of a 64-entry byte ring (63 bytes usable).
// Every transfer on req gives exactly one transfer on rsp. A message or sysex item
// writes one byte per cycle unless stalled (and takes a step even when nothing is
// written), since the byte memory has a single write port; read and peek take a
// step for the registered memory read and a further step to deliver. The next
// item is taken in the cycle the current one finishes, and a result waits in the
// output register while the following item already runs; only the final cycle of
// an item stalls if the previous result has not been taken. Running status is
// decided when the item is taken. The byte memory has no reset and needs no clearing.
module midi_running_status_serializer_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [6:0]       cfg_data,
	mrss_req_if.sink         req,
	mrss_rsp_if.source       rsp
);

	localparam int PW = mrss_pkg::PTR_W;
	localparam logic [PW-1:0] PTR_LAST = PW'(mrss_pkg::FIFO_DEPTH - 1);
	localparam logic [PW:0]   DEPTH_X  = (PW+1)'(mrss_pkg::FIFO_DEPTH);

	// control
	logic             busy_q;
	logic [1:0]       idx_q;
	logic [1:0]       last_idx_q;
	logic [2:0]       nbytes_q;
	logic             is_rd_q;
	logic             is_pop_q;
	logic [2:0]       drop_q;
	mrss_pkg::ptr_t   wp_q;
	mrss_pkg::ptr_t   rp_q;
	logic [7:0]       last_status_q;
	logic [6:0]       manuf_q;
	logic [6:0]       prod_q;
	logic             out_valid_q;

	// payload
	logic [7:0]       bytes_q [4];
	logic [7:0]       read_byte_q;
	logic             was_empty_q;
	logic [2:0]       dropped_q;
	logic [5:0]       fill_q;

	logic             out_free, last_step, step_en, finish, accept;
	logic             wr_this, full, push, drop_now, fifo_empty, pop;
	mrss_pkg::ptr_t   wp_inc, rp_inc, wp_nxt, rp_nxt;
	logic [PW:0]      fill_w;
	logic [7:0]       ram_rdata;

	// item decode at the input
	logic             emit;
	logic [7:0]       rs_nxt;
	logic [7:0]       dec_bytes [4];
	logic [2:0]       dec_n;
	logic [1:0]       dec_last;
	logic             dec_rd, dec_pop;

	always_comb begin
		emit         = 1'b0;
		rs_nxt       = last_status_q;
		dec_bytes[0] = {1'b0, req.data_first};
		dec_bytes[1] = {1'b0, req.data_second};
		dec_bytes[2] = {1'b0, req.data_second};
		dec_bytes[3] = req.payload_byte;
		dec_n        = 3'd0;
		dec_rd       = 1'b0;
		dec_pop      = 1'b0;
		unique case (req.op)
			mrss_pkg::OP_MSG: begin
				if (req.status_byte >= mrss_pkg::ST_REALTIME) begin
					emit = 1'b1;
				end else if (req.status_byte >= mrss_pkg::ST_SYSEX) begin
					emit   = 1'b1;
					rs_nxt = mrss_pkg::ST_NONE;
				end else if (req.status_byte != last_status_q) begin
					emit   = 1'b1;
					rs_nxt = req.status_byte;
				end
				// drop the status slot when running status applies
				if (emit) begin
					dec_bytes[0] = req.status_byte;
					dec_bytes[1] = {1'b0, req.data_first};
				end
				dec_n = {2'b00, emit} + ((req.message_length > 2'd1) ? 3'd1 : 3'd0)
					+ ((req.message_length > 2'd2) ? 3'd1 : 3'd0);
			end
			mrss_pkg::OP_SX_BEGIN: begin
				dec_bytes[0] = mrss_pkg::ST_SYSEX;
				dec_bytes[1] = {1'b0, manuf_q};
				dec_bytes[2] = {1'b0, prod_q};
				dec_bytes[3] = req.payload_byte;
				dec_n        = 3'd4;
			end
			mrss_pkg::OP_SX_DATA: begin
				dec_bytes[0] = req.payload_byte;
				dec_n        = 3'd1;
			end
			mrss_pkg::OP_SX_END: begin
				dec_bytes[0] = mrss_pkg::ST_EOX;
				dec_n        = 3'd1;
				rs_nxt       = mrss_pkg::ST_NONE;
			end
			mrss_pkg::OP_READ: begin
				dec_rd  = 1'b1;
				dec_pop = 1'b1;
			end
			mrss_pkg::OP_PEEK: begin
				dec_rd = 1'b1;
			end
			default: begin
			end
		endcase
		if (dec_rd) begin
			dec_last = 2'd1;
		end else if (dec_n == 3'd0) begin
			dec_last = 2'd0;
		end else begin
			dec_last = 2'(dec_n - 3'd1);
		end
	end

	// sequencer
	assign out_free  = !out_valid_q || rsp.ready;
	assign last_step = busy_q && (idx_q == last_idx_q);
	assign step_en   = busy_q && (!last_step || out_free);
	assign finish    = step_en && last_step;
	assign req.ready = !busy_q || finish;
	assign accept    = req.valid && req.ready;

	assign wp_inc   = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
	assign rp_inc   = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
	assign wr_this  = step_en && ({1'b0, idx_q} < nbytes_q);
	assign full     = (wp_inc == rp_q);
	assign push     = wr_this && !full;
	assign drop_now = wr_this && full;
	assign wp_nxt   = push ? wp_inc : wp_q;

	assign fifo_empty = (rp_q == wp_q);
	assign pop        = finish && is_pop_q && !fifo_empty;
	assign rp_nxt     = pop ? rp_inc : rp_q;

	assign fill_w = {1'b0, wp_nxt} - {1'b0, rp_nxt} + ((wp_nxt < rp_nxt) ? DEPTH_X : '0);

	// read port follows the read pointer; the registered read data sees the last
	// write of the previous item by the time a read or peek delivers
	mrss_ram #(
		.WIDTH(8),
		.DEPTH(mrss_pkg::FIFO_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (push),
		.waddr(wp_q),
		.wdata(bytes_q[idx_q]),
		.raddr(rp_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			idx_q         <= '0;
			last_idx_q    <= '0;
			nbytes_q      <= '0;
			is_rd_q       <= 1'b0;
			is_pop_q      <= 1'b0;
			drop_q        <= '0;
			wp_q          <= '0;
			rp_q          <= '0;
			last_status_q <= mrss_pkg::ST_NONE;
			manuf_q       <= mrss_pkg::MANUF_ID_RST;
			prod_q        <= mrss_pkg::PRODUCT_ID_RST;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					mrss_pkg::CFG_MANUF_ID:   manuf_q <= cfg_data;
					mrss_pkg::CFG_PRODUCT_ID: prod_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			wp_q <= wp_nxt;
			rp_q <= rp_nxt;
			if (accept) begin
				busy_q        <= 1'b1;
				idx_q         <= '0;
				last_idx_q    <= dec_last;
				nbytes_q      <= dec_n;
				is_rd_q       <= dec_rd;
				is_pop_q      <= dec_pop;
				drop_q        <= '0;
				last_status_q <= rs_nxt;
			end else begin
				if (step_en) begin
					idx_q  <= idx_q + 2'd1;
					drop_q <= drop_q + {2'b00, drop_now};
				end
				if (finish) begin
					busy_q <= 1'b0;
				end
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bytes_q <= dec_bytes;
		end
		if (finish) begin
			read_byte_q <= (is_rd_q && !fifo_empty) ? ram_rdata : 8'd0;
			was_empty_q <= is_rd_q && fifo_empty;
			dropped_q   <= drop_q + {2'b00, drop_now};
			fill_q      <= 6'(fill_w);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.read_byte     = read_byte_q;
	assign rsp.was_empty     = was_empty_q;
	assign rsp.bytes_dropped = dropped_q;
	assign rsp.fill_level    = fill_q;

endmodule

// ----- rtl/mrss_ram.sv -----
`timescale 1ns / 1ps

module mrss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/mrss_checker.sv -----
`timescale 1ns / 1ps

module mrss_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_read_byte,
	input logic       rsp_was_empty,
	input logic [2:0] rsp_bytes_dropped,
	input logic [5:0] rsp_fill_level
);

	localparam logic [5:0] FULL_FILL = 6'(mrss_pkg::FIFO_DEPTH - 1);

	// a result that is not taken stays as it is
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_byte)
			&& $stable(rsp_was_empty) && $stable(rsp_bytes_dropped)
			&& $stable(rsp_fill_level))
		else $error("rsp changed while stalled");

	// an empty read reports no byte and an empty ring
	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_was_empty |-> rsp_read_byte == 8'd0 && rsp_fill_level == 6'd0)
		else $error("empty read with data or fill");

	// bytes only drop into a full ring, and it is still full afterwards
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_bytes_dropped != 3'd0 |-> rsp_fill_level == FULL_FILL)
		else $error("drop reported without a full ring");

	// an item drops bytes or reads, never both, and drops at most four
	a_drop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_bytes_dropped <= 3'd4
			&& !(rsp_was_empty && rsp_bytes_dropped != 3'd0))
		else $error("bad drop count");

endmodule

bind midi_running_status_serializer_core mrss_checker u_mrss_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_read_byte    (rsp.read_byte),
	.rsp_was_empty    (rsp.was_empty),
	.rsp_bytes_dropped(rsp.bytes_dropped),
	.rsp_fill_level   (rsp.fill_level)
);
